/* hw/rtl/silhouette_edge_detector_unit_assert.svh */
// Assertion macros for the silhouette edge detector.
// Expects clk and rst_n in the scope of use.
`ifndef SILHOUETTE_EDGE_DETECTOR_UNIT_ASSERT_SVH
`define SILHOUETTE_EDGE_DETECTOR_UNIT_ASSERT_SVH

// same-cycle implication
`define SED_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// next-cycle implication
`define SED_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

/* hw/rtl/sed_pkg.sv */
// Shared types and constants for the silhouette edge detector.
// No dependencies.
package sed_pkg;

  localparam int SED_MAX_FACES         = 4096;
  localparam int SED_VERTEX_INDEX_BITS = 16;
  localparam int SED_FACE_IDX_W        = 12;
  localparam int SED_VIDX_W            = 16;
  localparam int SED_CFG_IDX_W         = 3;

  localparam logic signed [31:0] SED_LIGHT_W_RST = 32'sd65536;
  localparam logic [30:0]        SED_THRESH_RST  = 31'd107374;

  localparam logic [SED_CFG_IDX_W-1:0] CFG_LIGHT_X = 3'd0;
  localparam logic [SED_CFG_IDX_W-1:0] CFG_LIGHT_Y = 3'd1;
  localparam logic [SED_CFG_IDX_W-1:0] CFG_LIGHT_Z = 3'd2;
  localparam logic [SED_CFG_IDX_W-1:0] CFG_LIGHT_W = 3'd3;
  localparam logic [SED_CFG_IDX_W-1:0] CFG_THRESH  = 3'd4;

  localparam logic MODE_FACE = 1'b0;
  localparam logic MODE_EDGE = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_SAT,
    S_DOT,
    S_SUM,
    S_RDA,
    S_RDB,
    S_EFIN
  } sed_state_t;

  typedef struct packed {
    logic mul_en;
    logic sat_en;
    logic dot_en;
  } sed_calc_ctl_t;

endpackage

/* hw/rtl/sed_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module sed_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/sed_face_calc.sv */
// Face facing test: w*v products, floor shift and clamp, subtract light, dot with normal, threshold.
// Depends on sed_pkg.
module sed_face_calc import sed_pkg::*; (
  input  logic               clk,
  input  sed_calc_ctl_t      ctl,
  input  logic signed [31:0] light_x,
  input  logic signed [31:0] light_y,
  input  logic signed [31:0] light_z,
  input  logic signed [31:0] light_w,
  input  logic [30:0]        threshold,
  input  logic signed [15:0] normal_x,
  input  logic signed [15:0] normal_y,
  input  logic signed [15:0] normal_z,
  input  logic signed [31:0] vert_x,
  input  logic signed [31:0] vert_y,
  input  logic signed [31:0] vert_z,
  output logic               lit,
  output logic               sat
);

  logic signed [31:0] v_a [3];
  logic signed [31:0] l_a [3];
  logic signed [15:0] n_a [3];
  logic signed [63:0] prod_r [3];
  logic signed [32:0] diff_r [3];
  logic signed [32:0] diff_nxt [3];
  logic signed [48:0] dot_r [3];
  logic [2:0]         clamp;
  logic               sat_r;
  logic signed [50:0] sum;

  assign v_a[0] = vert_x;
  assign v_a[1] = vert_y;
  assign v_a[2] = vert_z;
  assign l_a[0] = light_x;
  assign l_a[1] = light_y;
  assign l_a[2] = light_z;
  assign n_a[0] = normal_x;
  assign n_a[1] = normal_y;
  assign n_a[2] = normal_z;

  for (genvar i = 0; i < 3; i++) begin : g_lane
    logic signed [47:0] q;
    logic signed [31:0] s;

    always_comb begin
      q        = prod_r[i][63:16];
      clamp[i] = (q[47:31] != {17{q[47]}});
      if (clamp[i]) begin
        s = q[47] ? 32'sh8000_0000 : 32'sh7fff_ffff;
      end else begin
        s = q[31:0];
      end
      diff_nxt[i] = {s[31], s} - {l_a[i][31], l_a[i]};
    end

    always_ff @(posedge clk) begin
      if (ctl.mul_en) begin
        prod_r[i] <= light_w * v_a[i];
      end
      if (ctl.sat_en) begin
        diff_r[i] <= diff_nxt[i];
      end
      if (ctl.dot_en) begin
        dot_r[i] <= n_a[i] * diff_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.sat_en) begin
      sat_r <= |clamp;
    end
  end

  assign sum = 51'(dot_r[0]) + 51'(dot_r[1]) + 51'(dot_r[2]);
  assign lit = sum > $signed({20'd0, threshold});
  assign sat = sat_r;

endmodule

/* hw/rtl/silhouette_edge_detector_unit.sv */
// Silhouette edge detector top: config registers, sequencer, lit-flag RAM, result register.
// Depends on sed_pkg, sed_face_calc, sed_ram and the assertion macro header.
//
//  channel  | handshake             | beat
//  ---------+-----------------------+-----------------------------------------
//  input    | start / busy          | in_mode, face, normal, vertex, edge data
//  result   | out_valid (strobe)    | out_result_kind .. out_product_saturated
//  config   | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// Face beat: from accept to next accept, set by the three-stage
// multiply chain (w*v, clamp/subtract, normal dot) and the sum/compare.
// Edge beat: set by two reads on the single RAM read port.
// Result strobe is high one cycle, in the cycle after the last step; busy is
// already low then. Reset clears control and config; flag RAM is not cleared.
// Receiver cannot stall; cfg_ready is always high.
`include "silhouette_edge_detector_unit_assert.svh"

module silhouette_edge_detector_unit import sed_pkg::*; #(
  parameter int MAX_FACES         = SED_MAX_FACES,
  parameter int VERTEX_INDEX_BITS = SED_VERTEX_INDEX_BITS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic                     in_mode,
  input  logic [SED_FACE_IDX_W-1:0] in_face_index,
  input  logic signed [15:0]       in_normal_x,
  input  logic signed [15:0]       in_normal_y,
  input  logic signed [15:0]       in_normal_z,
  input  logic signed [31:0]       in_vert_x,
  input  logic signed [31:0]       in_vert_y,
  input  logic signed [31:0]       in_vert_z,
  input  logic [SED_FACE_IDX_W-1:0] in_edge_face_a,
  input  logic [SED_FACE_IDX_W-1:0] in_edge_face_b,
  input  logic [SED_VIDX_W-1:0]    in_edge_vert_a,
  input  logic [SED_VIDX_W-1:0]    in_edge_vert_b,
  output logic                     out_valid,
  output logic                     out_result_kind,
  output logic                     out_face_lit,
  output logic                     out_on_silhouette,
  output logic [SED_VIDX_W-1:0]    out_start_vertex,
  output logic [SED_VIDX_W-1:0]    out_end_vertex,
  output logic                     out_product_saturated,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [SED_CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]              cfg_data
);

  localparam int AW  = (MAX_FACES > 1) ? $clog2(MAX_FACES) : 1;
  localparam int XW  = AW + SED_FACE_IDX_W;
  localparam logic [XW-1:0] MAXF = XW'(MAX_FACES);
  localparam int VMB = (VERTEX_INDEX_BITS < SED_VIDX_W) ? VERTEX_INDEX_BITS : SED_VIDX_W;
  localparam logic [SED_VIDX_W-1:0] VMASK = SED_VIDX_W'((64'd1 << VMB) - 64'd1);

  sed_state_t state_r, state_nxt;
  sed_calc_ctl_t calc_ctl;

  logic signed [31:0] light_x_r, light_y_r, light_z_r, light_w_r;
  logic [30:0]        thresh_r;

  logic [SED_FACE_IDX_W-1:0] face_idx_r, efa_r, efb_r;
  logic signed [15:0]        nx_r, ny_r, nz_r;
  logic signed [31:0]        vx_r, vy_r, vz_r;
  logic [SED_VIDX_W-1:0]     eva_r, evb_r;

  logic          accept;
  logic [XW-1:0] fi_x, fa_x, fb_x;
  logic          fi_ok, fa_ok, fb_ok;
  logic          ram_we;
  logic [AW-1:0] ram_raddr;
  logic [0:0]    ram_rdata;
  logic          la_r, la_nxt, lb;
  logic          lit, sat;

  logic                  out_valid_r, out_valid_nxt;
  logic                  kind_r, kind_nxt;
  logic                  flit_r, flit_nxt;
  logic                  onsil_r, onsil_nxt;
  logic [SED_VIDX_W-1:0] sv_r, sv_nxt, ev_r, ev_nxt;
  logic                  psat_r, psat_nxt;
  logic                  out_load;

  assign accept    = start && !busy;
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      light_x_r <= '0;
      light_y_r <= '0;
      light_z_r <= '0;
      light_w_r <= SED_LIGHT_W_RST;
      thresh_r  <= SED_THRESH_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_LIGHT_X: light_x_r <= cfg_data;
        CFG_LIGHT_Y: light_y_r <= cfg_data;
        CFG_LIGHT_Z: light_z_r <= cfg_data;
        CFG_LIGHT_W: light_w_r <= cfg_data;
        CFG_THRESH:  thresh_r  <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      face_idx_r <= in_face_index;
      nx_r       <= in_normal_x;
      ny_r       <= in_normal_y;
      nz_r       <= in_normal_z;
      vx_r       <= in_vert_x;
      vy_r       <= in_vert_y;
      vz_r       <= in_vert_z;
      efa_r      <= in_edge_face_a;
      efb_r      <= in_edge_face_b;
      eva_r      <= in_edge_vert_a;
      evb_r      <= in_edge_vert_b;
    end
  end

  assign fi_x  = XW'(face_idx_r);
  assign fa_x  = XW'(efa_r);
  assign fb_x  = XW'(efb_r);
  assign fi_ok = fi_x < MAXF;
  assign fa_ok = fa_x < MAXF;
  assign fb_ok = fb_x < MAXF;

  sed_face_calc u_calc (
    .clk       (clk),
    .ctl       (calc_ctl),
    .light_x   (light_x_r),
    .light_y   (light_y_r),
    .light_z   (light_z_r),
    .light_w   (light_w_r),
    .threshold (thresh_r),
    .normal_x  (nx_r),
    .normal_y  (ny_r),
    .normal_z  (nz_r),
    .vert_x    (vx_r),
    .vert_y    (vy_r),
    .vert_z    (vz_r),
    .lit       (lit),
    .sat       (sat)
  );

  sed_ram #(
    .WIDTH (1),
    .DEPTH (MAX_FACES),
    .AW    (AW)
  ) u_flags (
    .clk   (clk),
    .we    (ram_we),
    .waddr (fi_x[AW-1:0]),
    .wdata (lit),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign lb = ram_rdata[0] && fb_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    la_r <= la_nxt;
    if (out_load) begin
      kind_r  <= kind_nxt;
      flit_r  <= flit_nxt;
      onsil_r <= onsil_nxt;
      sv_r    <= sv_nxt;
      ev_r    <= ev_nxt;
      psat_r  <= psat_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    calc_ctl      = '0;
    ram_we        = 1'b0;
    ram_raddr     = fa_x[AW-1:0];
    la_nxt        = la_r;
    out_load      = 1'b0;
    out_valid_nxt = 1'b0;
    kind_nxt      = MODE_FACE;
    flit_nxt      = 1'b0;
    onsil_nxt     = 1'b0;
    sv_nxt        = '0;
    ev_nxt        = '0;
    psat_nxt      = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = (in_mode == MODE_EDGE) ? S_RDA : S_MUL;
        end
      end
      S_MUL: begin
        calc_ctl.mul_en = 1'b1;
        state_nxt       = S_SAT;
      end
      S_SAT: begin
        calc_ctl.sat_en = 1'b1;
        state_nxt       = S_DOT;
      end
      S_DOT: begin
        calc_ctl.dot_en = 1'b1;
        state_nxt       = S_SUM;
      end
      S_SUM: begin
        ram_we        = fi_ok;
        out_load      = 1'b1;
        out_valid_nxt = 1'b1;
        kind_nxt      = MODE_FACE;
        flit_nxt      = lit;
        psat_nxt      = sat;
        state_nxt     = S_IDLE;
      end
      S_RDA: begin
        ram_raddr = fa_x[AW-1:0];
        state_nxt = S_RDB;
      end
      S_RDB: begin
        ram_raddr = fb_x[AW-1:0];
        la_nxt    = ram_rdata[0] && fa_ok;
        state_nxt = S_EFIN;
      end
      S_EFIN: begin
        out_load      = 1'b1;
        out_valid_nxt = 1'b1;
        kind_nxt      = MODE_EDGE;
        onsil_nxt     = la_r ^ lb;
        sv_nxt        = (la_r ? eva_r : evb_r) & VMASK;
        ev_nxt        = (la_r ? evb_r : eva_r) & VMASK;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid             = out_valid_r;
  assign out_result_kind       = kind_r;
  assign out_face_lit          = flit_r;
  assign out_on_silhouette     = onsil_r;
  assign out_start_vertex      = sv_r;
  assign out_end_vertex        = ev_r;
  assign out_product_saturated = psat_r;

  `SED_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `SED_ASSERT_NEXT(a_strobe_single, out_valid, !out_valid)
  `SED_ASSERT_SAME(a_we_in_sum, ram_we, state_r == S_SUM)
  `SED_ASSERT_SAME(a_out_after_last, out_valid, !busy && $past(out_load))

endmodule
